FILE: rtl/egcd_pkg.sv
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared types, constants and the control store of the gcd unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

	// field widths of the request and result
	localparam int FIELD_W       = 32;
	localparam int OPERAND_W_DEF = 32;

	// microprogram addresses
	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE    = 3'd0;
	localparam step_t STEP_TEST    = 3'd1;
	localparam step_t STEP_DIVINIT = 3'd2;
	localparam step_t STEP_DIVSTEP = 3'd3;
	localparam step_t STEP_SWAP    = 3'd4;
	localparam step_t STEP_DONE    = 3'd5;

	// branch conditions
	typedef enum logic [2:0] {
		COND_ALWAYS   = 3'd0,
		COND_IN_REQ   = 3'd1,
		COND_B_ZERO   = 3'd2,
		COND_CNT_LAST = 3'd3,
		COND_OUT_FREE = 3'd4
	} cond_t;

	// datapath controls
	typedef struct packed {
		logic load;
		logic div_init;
		logic div_step;
		logic swap;
	} dp_ctrl_t;

	// datapath status
	typedef struct packed {
		logic b_zero;
		logic cnt_last;
	} dp_stat_t;

	// one control word
	typedef struct packed {
		cond_t    cond;
		step_t    addr_true;
		step_t    addr_false;
		logic     gated;
		logic     out_load;
		dp_ctrl_t dp;
	} uword_t;

	// control store
	function automatic uword_t ucode_rom(input step_t addr);
		uword_t w;
		w = '{cond: COND_ALWAYS, addr_true: STEP_IDLE, addr_false: STEP_IDLE,
			gated: 1'b0, out_load: 1'b0, dp: '0};
		case (addr)
			STEP_IDLE: begin
				w.cond       = COND_IN_REQ;
				w.addr_true  = STEP_TEST;
				w.addr_false = STEP_IDLE;
				w.gated      = 1'b1;
				w.dp.load    = 1'b1;
			end
			STEP_TEST: begin
				w.cond       = COND_B_ZERO;
				w.addr_true  = STEP_DONE;
				w.addr_false = STEP_DIVINIT;
			end
			STEP_DIVINIT: begin
				w.addr_true   = STEP_DIVSTEP;
				w.dp.div_init = 1'b1;
			end
			STEP_DIVSTEP: begin
				w.cond        = COND_CNT_LAST;
				w.addr_true   = STEP_SWAP;
				w.addr_false  = STEP_DIVSTEP;
				w.dp.div_step = 1'b1;
			end
			STEP_SWAP: begin
				w.addr_true = STEP_TEST;
				w.dp.swap   = 1'b1;
			end
			STEP_DONE: begin
				w.cond       = COND_OUT_FREE;
				w.addr_true  = STEP_IDLE;
				w.addr_false = STEP_DONE;
				w.gated      = 1'b1;
				w.out_load   = 1'b1;
			end
			default: begin
				w.addr_true = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/egcd_datapath.sv
// ----------------------------------------------------------------------------
// egcd_datapath
// Working pair registers and a restoring shift-subtract remainder unit.
// ----------------------------------------------------------------------------
module egcd_datapath #(
	parameter int OPERAND_WIDTH = egcd_pkg::OPERAND_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  egcd_pkg::dp_ctrl_t           ctrl,
	input  logic [egcd_pkg::FIELD_W-1:0] first_operand,
	input  logic [egcd_pkg::FIELD_W-1:0] second_operand,
	output egcd_pkg::dp_stat_t           stat,
	output logic [egcd_pkg::FIELD_W-1:0] result
);

	localparam int CNT_W = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

	logic [OPERAND_WIDTH-1:0] a_ld;
	logic [OPERAND_WIDTH-1:0] b_ld;
	logic [OPERAND_WIDTH-1:0] a_q;
	logic [OPERAND_WIDTH-1:0] b_q;
	logic [OPERAND_WIDTH-1:0] rem_q;
	logic [OPERAND_WIDTH-1:0] shf_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [OPERAND_WIDTH:0]   trial;
	logic [OPERAND_WIDTH:0]   diff;
	logic [OPERAND_WIDTH-1:0] rem_nxt;

	// operand masking to the working width
	if (OPERAND_WIDTH <= egcd_pkg::FIELD_W) begin : g_narrow_in
		assign a_ld = first_operand[OPERAND_WIDTH-1:0];
		assign b_ld = second_operand[OPERAND_WIDTH-1:0];
	end else begin : g_wide_in
		assign a_ld = {{(OPERAND_WIDTH-egcd_pkg::FIELD_W){1'b0}}, first_operand};
		assign b_ld = {{(OPERAND_WIDTH-egcd_pkg::FIELD_W){1'b0}}, second_operand};
	end

	// result carries the low field bits
	if (OPERAND_WIDTH >= egcd_pkg::FIELD_W) begin : g_wide_out
		assign result = a_q[egcd_pkg::FIELD_W-1:0];
	end else begin : g_narrow_out
		assign result = {{(egcd_pkg::FIELD_W-OPERAND_WIDTH){1'b0}}, a_q};
	end

	// one remainder bit per step
	always_comb begin
		trial   = {rem_q, shf_q[OPERAND_WIDTH-1]};
		diff    = trial - {1'b0, b_q};
		rem_nxt = diff[OPERAND_WIDTH] ? trial[OPERAND_WIDTH-1:0] : diff[OPERAND_WIDTH-1:0];
	end

	// status towards the sequencer
	assign stat.b_zero   = (b_q == '0);
	assign stat.cnt_last = (cnt_q == '0);

	// working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q   <= '0;
			b_q   <= '0;
			rem_q <= '0;
			shf_q <= '0;
			cnt_q <= '0;
		end else begin
			if (ctrl.load) begin
				a_q <= a_ld;
				b_q <= b_ld;
			end else if (ctrl.swap) begin
				a_q <= b_q;
				b_q <= rem_q;
			end
			if (ctrl.div_init) begin
				rem_q <= '0;
				shf_q <= a_q;
				cnt_q <= CNT_W'(OPERAND_WIDTH - 1);
			end else if (ctrl.div_step) begin
				rem_q <= rem_nxt;
				shf_q <= {shf_q[OPERAND_WIDTH-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/euclid_gcd_unit.sv
// ----------------------------------------------------------------------------
// euclid_gcd_unit
// Greatest common divisor of two unsigned operands by Euclid's rule.
// ----------------------------------------------------------------------------
// One request is worked at a time. A microprogram steps a shared remainder
// unit that produces one remainder bit per cycle; each Euclid iteration
// (a, b) <- (b, a mod b) runs the test, divide-init, divide-step and swap
// steps. The number of iterations is 0 when the second operand is zero and
// at most about 1.44 * OPERAND_WIDTH. The next request can be taken in the
// cycle after the result is loaded. gcd(a, 0) = a and gcd(0, 0) = 0. Operand
// bits above OPERAND_WIDTH are ignored. The result sits in an output
// register, so the next request is taken while it waits to be collected.
// ----------------------------------------------------------------------------
module euclid_gcd_unit #(
	parameter int OPERAND_WIDTH = egcd_pkg::OPERAND_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [egcd_pkg::FIELD_W-1:0] first_operand,
	input  logic [egcd_pkg::FIELD_W-1:0] second_operand,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [egcd_pkg::FIELD_W-1:0] divisor
);

	egcd_pkg::step_t            pc_q;
	egcd_pkg::uword_t           uword;
	egcd_pkg::dp_ctrl_t         dp_ctrl;
	egcd_pkg::dp_stat_t         dp_stat;
	logic                       cond_true;
	logic                       act;
	logic                       out_free;
	logic                       out_valid_q;
	logic [egcd_pkg::FIELD_W-1:0] divisor_q;
	logic [egcd_pkg::FIELD_W-1:0] result;

	// control store read
	assign uword = egcd_pkg::ucode_rom(pc_q);

	assign in_ready = (pc_q == egcd_pkg::STEP_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// branch condition select
	always_comb begin
		case (uword.cond)
			egcd_pkg::COND_ALWAYS:   cond_true = 1'b1;
			egcd_pkg::COND_IN_REQ:   cond_true = in_valid;
			egcd_pkg::COND_B_ZERO:   cond_true = dp_stat.b_zero;
			egcd_pkg::COND_CNT_LAST: cond_true = dp_stat.cnt_last;
			egcd_pkg::COND_OUT_FREE: cond_true = out_free;
			default:                 cond_true = 1'b1;
		endcase
	end

	// actions of a gated word fire only when its condition holds
	assign act     = !uword.gated || cond_true;
	assign dp_ctrl = act ? uword.dp : '0;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= egcd_pkg::STEP_IDLE;
		end else begin
			pc_q <= cond_true ? uword.addr_true : uword.addr_false;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (act && uword.out_load) || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (act && uword.out_load) begin
			divisor_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign divisor   = divisor_q;

	// working pair and remainder unit
	egcd_datapath #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (dp_ctrl),
		.first_operand (first_operand),
		.second_operand(second_operand),
		.stat          (dp_stat),
		.result        (result)
	);

endmodule

FILE: tb/gcd_result_check.sv
// ----------------------------------------------------------------------------
// gcd_result_check
// Predicts and compares the results of the gcd unit.
// ----------------------------------------------------------------------------
// Watches both channels. Every accepted request gets its greatest common
// divisor worked out by Euclid's rule and queued. Every accepted result is
// compared with the oldest queued divisor. The mismatch count and the number
// of divisors still owed are handed back as registered counts.
// ----------------------------------------------------------------------------
module gcd_result_check #(
	parameter int OPERAND_WIDTH = egcd_pkg::OPERAND_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [egcd_pkg::FIELD_W-1:0] first_operand,
	input  logic [egcd_pkg::FIELD_W-1:0] second_operand,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [egcd_pkg::FIELD_W-1:0] divisor,
	output int                           mismatches,
	output int                           pending
);

	// operand bits above the configured width take no part in the work
	localparam logic [63:0] OPND_MASK = (OPERAND_WIDTH >= 64) ? {64{1'b1}} :
		((64'd1 << OPERAND_WIDTH) - 64'd1);

	logic [egcd_pkg::FIELD_W-1:0] expected_divisors[$];
	logic [egcd_pkg::FIELD_W-1:0] oldest_divisor;
	int                           mismatch_total;

	// euclid's rule: (a, b) <- (b, a mod b) until b is zero
	function automatic logic [egcd_pkg::FIELD_W-1:0] euclid_divisor(
		input logic [egcd_pkg::FIELD_W-1:0] first_in,
		input logic [egcd_pkg::FIELD_W-1:0] second_in
	);
		logic [63:0] dividend;
		logic [63:0] div_by;
		logic [63:0] remainder;
		dividend = {32'd0, first_in} & OPND_MASK;
		div_by   = {32'd0, second_in} & OPND_MASK;
		while (div_by != 64'd0) begin
			remainder = dividend % div_by;
			dividend  = div_by;
			div_by    = remainder;
		end
		return dividend[egcd_pkg::FIELD_W-1:0];
	endfunction

	// results leave the queue before a request of the same edge joins it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_divisors.delete();
			mismatch_total = 0;
			mismatches     <= 0;
			pending        <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_divisors.size() == 0) begin
					$display("%0t: divisor %0d arrived with no request outstanding",
						$time, divisor);
					mismatch_total++;
				end else begin
					oldest_divisor = expected_divisors.pop_front();
					if (divisor !== oldest_divisor) begin
						$display("%0t: divisor mismatch, expected %0d, actual %0d",
							$time, oldest_divisor, divisor);
						mismatch_total++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_divisors.push_back(euclid_divisor(first_operand, second_operand));
			pending    <= expected_divisors.size();
			mismatches <= mismatch_total;
		end
	end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the euclid gcd unit.
// ----------------------------------------------------------------------------
// Drives operand pairs into the unit and collects the divisors, while a
// separate checker predicts each divisor and compares. A directed set covers
// zero operands, all-ones operands, equal and co-prime pairs and the longest
// Fibonacci chains; random pairs follow in four phases of sender idling and
// receiver stalling. One long receiver hold-off fills the unit, and the
// sender drains all results between phases. A watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module tb;

	localparam int RANDOM_ITEMS   = 1500;
	localparam int PHASES         = 4;
	localparam int HOLDOFF_CYCLES = 2000;
	localparam int TAIL_CYCLES    = 2000;
	localparam int WATCHDOG_LIMIT = 20000;

	logic                         clk            = 1'b0;
	logic                         arst_n         = 1'b0;
	logic                         in_valid       = 1'b0;
	logic                         out_ready      = 1'b0;
	logic [egcd_pkg::FIELD_W-1:0] first_operand  = '0;
	logic [egcd_pkg::FIELD_W-1:0] second_operand = '0;
	logic                         in_ready;
	logic                         out_valid;
	logic [egcd_pkg::FIELD_W-1:0] divisor;

	int          mismatches;
	int          pending;
	int unsigned idle_pct      = 0;
	int unsigned stall_pct     = 0;
	bit          holdoff_req   = 1'b0;
	int          holdoff_count = 0;
	int          quiet_cycles  = 0;

	int unsigned idle_plan[PHASES]  = '{0, 72, 0, 37};
	int unsigned stall_plan[PHASES] = '{0, 0, 72, 37};

	euclid_gcd_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.first_operand  (first_operand),
		.second_operand (second_operand),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.divisor        (divisor)
	);

	gcd_result_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.first_operand  (first_operand),
		.second_operand (second_operand),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.divisor        (divisor),
		.mismatches     (mismatches),
		.pending        (pending)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: random stalls, or a long hold-off when asked for
	always @(posedge clk) begin
		if (holdoff_req && holdoff_count < HOLDOFF_CYCLES) begin
			out_ready     <= 1'b0;
			holdoff_count <= holdoff_count + 1;
		end else begin
			if (holdoff_req) begin
				holdoff_req   <= 1'b0;
				holdoff_count <= 0;
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog: cycles with no handshake on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one request, with random idle cycles ahead of it
	task automatic offer_pair(input logic [egcd_pkg::FIELD_W-1:0] a,
		input logic [egcd_pkg::FIELD_W-1:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		first_operand  <= a;
		second_operand <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// stop offering until every divisor owed has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// consecutive fibonacci numbers: the longest chains of iterations
	function automatic void fib_pair(input int steps,
		output logic [egcd_pkg::FIELD_W-1:0] lo,
		output logic [egcd_pkg::FIELD_W-1:0] hi);
		logic [egcd_pkg::FIELD_W-1:0] nxt;
		lo = '0;
		hi = 32'd1;
		for (int i = 0; i < steps; i++) begin
			nxt = lo + hi;
			lo  = hi;
			hi  = nxt;
		end
	endfunction

	// random operand pair, mostly narrow so that the iterations stay few
	function automatic void pick_operands(output logic [egcd_pkg::FIELD_W-1:0] a,
		output logic [egcd_pkg::FIELD_W-1:0] b);
		int unsigned                  roll;
		logic [egcd_pkg::FIELD_W-1:0] mask;
		logic [egcd_pkg::FIELD_W-1:0] factor;
		logic [egcd_pkg::FIELD_W-1:0] swap_tmp;
		roll = $urandom_range(99);
		mask = (32'd1 << $urandom_range(16, 1)) - 32'd1;
		if (roll < 55) begin
			a = $urandom & mask;
			b = $urandom & mask;
		end else if (roll < 70) begin
			a = $urandom;
			b = $urandom;
		end else if (roll < 80) begin
			// shared factor so the divisor is not trivially one
			factor = $urandom_range(65535, 1);
			a      = factor * $urandom_range(65535);
			b      = factor * $urandom_range(65535);
		end else if (roll < 85) begin
			a = ($urandom_range(1)) ? $urandom : ($urandom & mask);
			b = '0;
		end else if (roll < 90) begin
			a = ($urandom_range(1)) ? $urandom : ($urandom & mask);
			b = a;
		end else if (roll < 95) begin
			b = $urandom & mask;
			a = b * $urandom_range(65535);
		end else begin
			fib_pair($urandom_range(46, 1), b, a);
		end
		if ($urandom_range(1)) begin
			swap_tmp = a;
			a        = b;
			b        = swap_tmp;
		end
	endfunction

	// stimulus and verdict
	initial begin
		logic [egcd_pkg::FIELD_W-1:0] op_a;
		logic [egcd_pkg::FIELD_W-1:0] op_b;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zeros, extremes, equal, co-prime, shared factors, worst chains
		offer_pair(32'd0, 32'd0);
		offer_pair(32'd0, 32'd12345);
		offer_pair(32'd987654, 32'd0);
		offer_pair(32'hFFFF_FFFF, 32'd0);
		offer_pair(32'd0, 32'hFFFF_FFFF);
		offer_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer_pair(32'hFFFF_FFFF, 32'd1);
		offer_pair(32'd1, 32'hFFFF_FFFF);
		offer_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		offer_pair(32'h8000_0000, 32'h4000_0000);
		offer_pair(32'hAAAA_AAAA, 32'h5555_5555);
		offer_pair(32'd1, 32'd1);
		offer_pair(32'd7, 32'd7);
		offer_pair(32'd12, 32'd18);
		offer_pair(32'd17, 32'd5);
		offer_pair(32'd48, 32'd180);
		offer_pair(32'd2971215073, 32'd1836311903);
		offer_pair(32'd1836311903, 32'd2971215073);
		offer_pair(32'd4294967291, 32'd4294967279);
		offer_pair(32'd65536, 32'd65535);
		drain_results();

		// random phases, each ending with a full drain
		for (int phase = 0; phase < PHASES; phase++) begin
			idle_pct  = idle_plan[phase];
			stall_pct = stall_plan[phase];
			// long receiver hold-off while requests keep coming
			if (phase == 0)
				holdoff_req <= 1'b1;
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				pick_operands(op_a, op_b);
				offer_pair(op_a, op_b);
			end
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
